// File: rtl/core/tpb_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the transformed point bounds unit.
// No dependencies; used by the channel interfaces and the top level.

package tpb_pkg;

   // default local coordinate width, signed Q(n-8).8
   localparam int COORD_WIDTH_DEF = 16;

   // matrix coefficients are signed Q4.12, translation signed Q8.8
   localparam int COEF_W = 16;
   localparam int FRAC_SHIFT = 12;
   localparam int ROUND_BIAS = 2048;

   // world-space result, signed Q16.8 saturated
   localparam int RESULT_W = 24;
   localparam int RESULT_MAX = 8388607;
   localparam int RESULT_MIN = -8388608;

   // configuration port
   localparam int CFG_W = 64;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_AXES = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Z = 2'd2;

   // reset rows give the identity matrix with zero translation
   localparam logic [CFG_W-1:0] ROW_X_RESET = 64'h1000_0000_0000_0000;
   localparam logic [CFG_W-1:0] ROW_Y_RESET = 64'h0000_1000_0000_0000;
   localparam logic [CFG_W-1:0] ROW_Z_RESET = 64'h0000_0000_1000_0000;

endpackage

// File: rtl/core/tpb_req_if.sv
`timescale 1ns / 1ps
// Vertex channel: valid/ready with local x, y, z and a last flag.
// Depends on tpb_pkg for the default coordinate width.

interface tpb_req_if #(
   parameter int COORD_W = tpb_pkg::COORD_WIDTH_DEF
);
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic signed [COORD_W-1:0] vertex_z;
   logic                      last_vertex;

   modport source (
      output valid, vertex_x, vertex_y, vertex_z, last_vertex,
      input  ready
   );

   modport sink (
      input  valid, vertex_x, vertex_y, vertex_z, last_vertex,
      output ready
   );
endinterface

// File: rtl/core/tpb_rsp_if.sv
`timescale 1ns / 1ps
// Bounding box channel: valid/ready with world-space min and max per axis.
// Depends on tpb_pkg for the result width.

interface tpb_rsp_if;
   import tpb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] bound_min_x;
   logic signed [RESULT_W-1:0] bound_min_y;
   logic signed [RESULT_W-1:0] bound_min_z;
   logic signed [RESULT_W-1:0] bound_max_x;
   logic signed [RESULT_W-1:0] bound_max_y;
   logic signed [RESULT_W-1:0] bound_max_z;

   modport source (
      output valid, bound_min_x, bound_min_y, bound_min_z,
             bound_max_x, bound_max_y, bound_max_z,
      input  ready
   );

   modport sink (
      input  valid, bound_min_x, bound_min_y, bound_min_z,
             bound_max_x, bound_max_y, bound_max_z,
      output ready
   );
endinterface

// File: rtl/core/transformed_point_bounds_unit.sv
`timescale 1ns / 1ps
// Transformed point bounds unit: affine transform plus running AABB.
// Depends on tpb_pkg, tpb_req_if and tpb_rsp_if.
//
// Usage:
//   req_chan carries local vertices (signed Q.8 x, y, z) and a last flag.
//   Each vertex goes through the 3x4 matrix held in csr rows 0..2
//   (x, y, z); a row packs three Q4.12 coefficients and a Q8.8 offset.
//   rsp_chan carries one world-space box (min/max per axis, Q16.8,
//   saturated to 24 bits) per run, on the vertex flagged last; the next
//   vertex then seeds a new run.
//   Path: after its last vertex transfers, a result passes through the
//   input register, product register, world-coordinate register, then
//   the result register.
//   Throughput: one vertex per cycle unless a last vertex holds for the
//   result register; the nine parallel multipliers and the per-axis compare keep pace.
//   Stall: non-last vertices keep flowing while a box waits on rsp_chan;
//   a last vertex holds in the world-coordinate stage until the result
//   register frees, and the stages behind it fill before req ready drops.
//   Reset: matrix rows return to identity, all stages empty, first
//   vertex seeds the bounds.
//   Matrix rows must be written only while no vertex is in flight; the block does not enforce this.

module transformed_point_bounds_unit #(
   parameter int COORD_WIDTH = tpb_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   tpb_req_if.sink                            req_chan,
   tpb_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [tpb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpb_pkg::CFG_W-1:0]          csr_wdata
);
   import tpb_pkg::*;

   localparam int PROD_W = COORD_WIDTH + COEF_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int Q_W    = SUM_W - FRAC_SHIFT;
   localparam int T_W    = ((Q_W > COEF_W) ? Q_W : COEF_W) + 1;
   localparam int EXT_W  = (T_W > RESULT_W + 1) ? T_W : RESULT_W + 1;

   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(RESULT_MAX);
   localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(RESULT_MIN);
   localparam logic signed [SUM_W-1:0] BIAS   = SUM_W'(ROUND_BIAS);

   // ---------------- matrix rows ----------------
   logic [CFG_W-1:0] row_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW_X_RESET;
         row_ff[1] <= ROW_Y_RESET;
         row_ff[2] <= ROW_Z_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROW_X: row_ff[0] <= csr_wdata;
            REG_ROW_Y: row_ff[1] <= csr_wdata;
            REG_ROW_Z: row_ff[2] <= csr_wdata;
            default: ; // unused index, write dropped
         endcase
      end
   end

   // ---------------- stage handshakes ----------------
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s0_last_ff, s1_last_ff, s2_last_ff;
   logic out_free, s3_take, s2_en, s1_en, s0_en;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // non-last vertices only touch the running bounds
   assign s3_take  = s2_valid_ff && (!s2_last_ff || out_free);
   assign s2_en    = !s2_valid_ff || s3_take;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign s0_en    = !s0_valid_ff || s1_en;

   assign req_chan.ready = s0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_en) s0_valid_ff <= req_chan.valid;
         if (s1_en) s1_valid_ff <= s0_valid_ff;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
      end
   end

   // ---------------- stage 0: input register ----------------
   logic signed [COORD_WIDTH-1:0] coord_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (s0_en) begin
         coord_ff[0] <= req_chan.vertex_x;
         coord_ff[1] <= req_chan.vertex_y;
         coord_ff[2] <= req_chan.vertex_z;
         s0_last_ff  <= req_chan.last_vertex;
      end
   end

   // ---------------- stage 1: nine products ----------------
   logic signed [PROD_W-1:0] prod_in [NUM_AXES][NUM_AXES];
   logic signed [PROD_W-1:0] prod_ff [NUM_AXES][NUM_AXES];

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            prod_in[r][k] = PROD_W'($signed(row_ff[r][CFG_W-1-COEF_W*k -: COEF_W])
                                    * coord_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         prod_ff    <= prod_in;
         s1_last_ff <= s0_last_ff;
      end
   end

   // ---------------- stage 2: sum, round, translate, saturate ----------------
   logic signed [SUM_W-1:0]    sum_r   [NUM_AXES];
   logic signed [Q_W-1:0]      quo_r   [NUM_AXES];
   logic signed [EXT_W-1:0]    world_r [NUM_AXES];
   logic signed [RESULT_W-1:0] world_in [NUM_AXES];
   logic signed [RESULT_W-1:0] world_ff [NUM_AXES];

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         sum_r[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                  + SUM_W'(prod_ff[r][2]) + BIAS;
         // arithmetic shift floors, so this rounds half toward +inf
         quo_r[r] = sum_r[r][SUM_W-1:FRAC_SHIFT];
         world_r[r] = EXT_W'(quo_r[r]) + EXT_W'($signed(row_ff[r][COEF_W-1:0]));
         if (world_r[r] > SAT_HI) begin
            world_in[r] = SAT_HI[RESULT_W-1:0];
         end else if (world_r[r] < SAT_LO) begin
            world_in[r] = SAT_LO[RESULT_W-1:0];
         end else begin
            world_in[r] = world_r[r][RESULT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         world_ff   <= world_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------- stage 3: running bounds and result ----------------
   logic                       first_pending_ff;
   logic signed [RESULT_W-1:0] run_min_ff [NUM_AXES];
   logic signed [RESULT_W-1:0] run_max_ff [NUM_AXES];
   logic signed [RESULT_W-1:0] run_min_in [NUM_AXES];
   logic signed [RESULT_W-1:0] run_max_in [NUM_AXES];
   logic signed [RESULT_W-1:0] box_min_ff [NUM_AXES];
   logic signed [RESULT_W-1:0] box_max_ff [NUM_AXES];

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         if (first_pending_ff) begin
            run_min_in[r] = world_ff[r];
            run_max_in[r] = world_ff[r];
         end else begin
            run_min_in[r] = (world_ff[r] < run_min_ff[r]) ? world_ff[r] : run_min_ff[r];
            run_max_in[r] = (world_ff[r] > run_max_ff[r]) ? world_ff[r] : run_max_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         for (int r = 0; r < NUM_AXES; r++) begin
            run_min_ff[r] <= '0;
            run_max_ff[r] <= '0;
         end
      end else begin
         if (s3_take) begin
            run_min_ff       <= run_min_in;
            run_max_ff       <= run_max_in;
            first_pending_ff <= s2_last_ff;
         end
         if (s3_take && s2_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_take && s2_last_ff) begin
         box_min_ff <= run_min_in;
         box_max_ff <= run_max_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bound_min_x = box_min_ff[0];
   assign rsp_chan.bound_min_y = box_min_ff[1];
   assign rsp_chan.bound_min_z = box_min_ff[2];
   assign rsp_chan.bound_max_x = box_max_ff[0];
   assign rsp_chan.bound_max_y = box_max_ff[1];
   assign rsp_chan.bound_max_z = box_max_ff[2];

   // ---------------- checks ----------------
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_last_ff))
      else $error("result raised without a last vertex leaving stage 2");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (box_min_ff[0] <= box_max_ff[0]) &&
                       (box_min_ff[1] <= box_max_ff[1]) &&
                       (box_min_ff[2] <= box_max_ff[2]))
      else $error("bounding box min above max");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (s3_take && s2_last_ff) |=> first_pending_ff)
      else $error("run not rearmed after last vertex");

endmodule

// File: dv/tpb_bounds_checker.sv
`timescale 1ns / 1ps
// Bounds checker: tracks the matrix rows and the running world-space box,
// and compares every box transfer against the oldest predicted box.
// Depends on tpb_pkg, tpb_req_if and tpb_rsp_if.

module tpb_bounds_checker (
   input  logic                          clock,
   input  logic                          reset,
   tpb_req_if                            req,
   tpb_rsp_if                            rsp,
   input  logic                          csr_we,
   input  logic [tpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpb_pkg::CFG_W-1:0]     csr_wdata,
   output int                            error_count,
   output int                            boxes_pending,
   output int                            vertex_count,
   output int                            box_count
);
   import tpb_pkg::*;

   typedef logic signed [RESULT_W-1:0] world_type;

   typedef struct packed {
      world_type min_x;
      world_type min_y;
      world_type min_z;
      world_type max_x;
      world_type max_y;
      world_type max_z;
   } box_type;

   logic [CFG_W-1:0] matrix_row [NUM_AXES];
   world_type        low_bound  [NUM_AXES];
   world_type        high_bound [NUM_AXES];
   logic             seed_next;
   box_type          expected_boxes [$];

   // one world axis: Q4.12 x Q.8 products summed, rounded to Q.8, offset, clamped
   function automatic world_type world_coord(logic [CFG_W-1:0] row,
                                             longint cx, longint cy, longint cz);
      longint acc;
      longint q;
      acc = longint'(signed'(row[63:48])) * cx + longint'(signed'(row[47:32])) * cy
          + longint'(signed'(row[31:16])) * cz + ROUND_BIAS;
      q = (acc >>> FRAC_SHIFT) + longint'(signed'(row[15:0]));
      if (q > RESULT_MAX) q = RESULT_MAX;
      if (q < RESULT_MIN) q = RESULT_MIN;
      return world_type'(q);
   endfunction

   task automatic check_field(string name, world_type want, world_type got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      world_type w [NUM_AXES];
      box_type   got;
      box_type   want;
      box_type   done_box;
      if (reset) begin
         matrix_row[0] = ROW_X_RESET;
         matrix_row[1] = ROW_Y_RESET;
         matrix_row[2] = ROW_Z_RESET;
         for (int a = 0; a < NUM_AXES; a++) begin
            low_bound[a]  = '0;
            high_bound[a] = '0;
         end
         seed_next = 1'b1;
         expected_boxes.delete();
         error_count   = 0;
         vertex_count  = 0;
         box_count     = 0;
         boxes_pending = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ROW_X: matrix_row[0] = csr_wdata;
               REG_ROW_Y: matrix_row[1] = csr_wdata;
               REG_ROW_Z: matrix_row[2] = csr_wdata;
               default: ;
            endcase
         end

         if (rsp.valid && rsp.ready) begin
            got = {rsp.bound_min_x, rsp.bound_min_y, rsp.bound_min_z,
                   rsp.bound_max_x, rsp.bound_max_y, rsp.bound_max_z};
            box_count++;
            if (expected_boxes.size() == 0) begin
               error_count++;
               $display("%0t: box transfer with none expected: min %0d %0d %0d max %0d %0d %0d",
                        $time, got.min_x, got.min_y, got.min_z,
                        got.max_x, got.max_y, got.max_z);
            end else begin
               want = expected_boxes.pop_front();
               check_field("bound_min_x", want.min_x, got.min_x);
               check_field("bound_min_y", want.min_y, got.min_y);
               check_field("bound_min_z", want.min_z, got.min_z);
               check_field("bound_max_x", want.max_x, got.max_x);
               check_field("bound_max_y", want.max_y, got.max_y);
               check_field("bound_max_z", want.max_z, got.max_z);
            end
         end

         if (req.valid && req.ready) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               w[a] = world_coord(matrix_row[a], longint'(req.vertex_x),
                                  longint'(req.vertex_y), longint'(req.vertex_z));
               if (seed_next) begin
                  low_bound[a]  = w[a];
                  high_bound[a] = w[a];
               end else begin
                  if (w[a] < low_bound[a])  low_bound[a]  = w[a];
                  if (w[a] > high_bound[a]) high_bound[a] = w[a];
               end
            end
            seed_next = 1'b0;
            vertex_count++;
            if (req.last_vertex) begin
               done_box = {low_bound[0], low_bound[1], low_bound[2],
                           high_bound[0], high_bound[1], high_bound[2]};
               expected_boxes = {expected_boxes, done_box};
               seed_next = 1'b1;
            end
         end
         boxes_pending = expected_boxes.size();
      end
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the bounds unit bench: clock, reset, vertex and matrix stimulus,
// receiver stalls, watchdog and verdict. Depends on tpb_pkg, both channel
// interfaces, transformed_point_bounds_unit and tpb_bounds_checker.

module testbench;
   import tpb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_VERTICES = 172;
   localparam logic signed [COORD_WIDTH_DEF-1:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [COORD_WIDTH_DEF-1:0] COORD_MIN = 16'sh8000;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   int error_count;
   int boxes_pending;
   int vertex_count;
   int box_count;
   int send_idle_pct;
   int stall_pct;
   int idle_cycles;
   int matrix_settings;

   tpb_req_if #(.COORD_W(COORD_WIDTH_DEF)) req_if ();
   tpb_rsp_if rsp_if ();

   transformed_point_bounds_unit #(.COORD_WIDTH(COORD_WIDTH_DEF)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tpb_bounds_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .boxes_pending (boxes_pending),
      .vertex_count  (vertex_count),
      .box_count     (box_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // cycles without any transfer or register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic signed [COORD_WIDTH_DEF-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         default: return COORD_WIDTH_DEF'($urandom);
      endcase
   endfunction

   task automatic present_vertex(logic signed [COORD_WIDTH_DEF-1:0] x,
                                 logic signed [COORD_WIDTH_DEF-1:0] y,
                                 logic signed [COORD_WIDTH_DEF-1:0] z,
                                 logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.vertex_x    <= x;
      req_if.vertex_y    <= y;
      req_if.vertex_z    <= z;
      req_if.last_vertex <= last;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // stop sending and let every vertex in flight reach the box register
   task automatic settle();
      req_if.valid <= 1'b0;
      wait (boxes_pending == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_row(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_matrix(logic [CFG_W-1:0] row_x, logic [CFG_W-1:0] row_y,
                              logic [CFG_W-1:0] row_z);
      write_row(REG_ROW_X, row_x);
      write_row(REG_ROW_Y, row_y);
      write_row(REG_ROW_Z, row_z);
      write_row(REG_UNUSED, {$urandom, $urandom});
      matrix_settings++;
   endtask

   // meshes of random length, mostly short, a few long; content leans to extremes
   task automatic stream_meshes(int vertices);
      int left;
      int len;
      left = vertices;
      while (left > 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         if (len > left) len = left;
         for (int i = 0; i < len; i++)
            present_vertex(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
         left -= len;
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.vertex_x    = '0;
      req_if.vertex_y    = '0;
      req_if.vertex_z    = '0;
      req_if.last_vertex = 1'b0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      matrix_settings    = 1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // identity rows out of reset: single-vertex meshes and coordinate extremes
      present_vertex('0, '0, '0, 1'b1);
      present_vertex(COORD_MAX, COORD_MIN, -16'sd1, 1'b0);
      present_vertex(COORD_MIN, COORD_MAX, 16'sd1, 1'b0);
      present_vertex(16'sh0100, -16'sh0100, 16'sh0080, 1'b1);
      present_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      present_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      present_vertex(16'sh0005, -16'sh0003, 16'sh0002, 1'b0);
      present_vertex(-16'sh0005, 16'sh0003, -16'sh0002, 1'b1);
      settle();

      // largest coefficients and offsets; unused index must not disturb the rows
      load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
      present_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      present_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      present_vertex('0, '0, '0, 1'b1);
      present_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      present_vertex(-16'sd1, 16'sd1, -16'sd1, 1'b0);
      present_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               load_matrix(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                           64'h8000_8000_8000_8000);
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
               send_idle_pct = 74;
               stall_pct     = 0;
            end
            2: begin
               load_matrix('0, {$urandom, $urandom}, ROW_Z_RESET);
               send_idle_pct = 0;
               stall_pct     = 74;
            end
            default: begin
               load_matrix({$urandom, $urandom}, ROW_Y_RESET, {$urandom, $urandom});
               send_idle_pct = 21;
               stall_pct     = 21;
            end
         endcase
         stream_meshes(PHASE_VERTICES);
         settle();
      end

      $display("Streamed %0d vertices, checked %0d boxes under %0d matrix settings",
               vertex_count, box_count, matrix_settings);
      $display("Phases: free flow, sender gaps, receiver stalls, and both together");
      if (error_count == 0 && boxes_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/tpb_pkg.sv
rtl/core/tpb_req_if.sv
rtl/core/tpb_rsp_if.sv
rtl/core/transformed_point_bounds_unit.sv
dv/tpb_bounds_checker.sv
dv/testbench.sv
